[rtl/wrn_pkg.sv]
package wrn_pkg;

  // Default number of tracked dimensions.
  localparam int unsigned DimMaxDef = 64;

  // Fixed arithmetic widths.
  localparam int unsigned MeanW  = 48;  // Q15.32 mean
  localparam int unsigned M2W    = 64;  // Q32.32 sum of squared deviations
  localparam int unsigned DevW   = 49;  // magnitude of a Q15.32 difference
  localparam int unsigned ProdW  = 2 * DevW;
  localparam int unsigned DivW   = 64;  // dividend and quotient width
  localparam int unsigned DenW   = 32;  // divisor width
  localparam int unsigned MulSteps = DevW;

  // Configuration register indexes.
  localparam logic [1:0] CfgEps  = 2'd0;
  localparam logic [1:0] CfgClip = 2'd1;

  // Operation codes.
  localparam logic OpUpdate    = 1'b0;
  localparam logic OpNormalize = 1'b1;

  typedef struct packed {
    logic               op;
    logic [5:0]         elem_index;
    logic signed [31:0] sample;
  } wrn_in_t;

  typedef struct packed {
    logic signed [31:0] avg_out;
    logic [31:0]        variance_out;
    logic signed [31:0] normalized_out;
    logic [31:0]        obs_count_out;
  } wrn_out_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } wrn_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } wrn_div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV_MEAN,
    ST_DEV,
    ST_MUL,
    ST_ACC,
    ST_WRITE,
    ST_DIV_VAR,
    ST_SQRT,
    ST_DIV_NORM,
    ST_OUT
  } wrn_state_e;

endpackage

[rtl/welford_running_normalizer_unit.sv]
// The block takes one word at a time and stalls its input while busy; the next word is
// taken in the cycle after the result is raised, and an out-of-range dimension goes
// straight to the output state. The time is set by the bit-serial divider (64 steps,
// used up to twice a word), the 49-step shift-add multiplier and the 32-step square
// root. Reset is asynchronous and active low; after reset a clearing pass zeroes the
// statistics memories before any word.
module welford_running_normalizer_unit #(
  parameter int unsigned DIM_MAX = wrn_pkg::DimMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wrn_pkg::wrn_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wrn_pkg::wrn_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import wrn_pkg::*;

  localparam int unsigned AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

  // The per-dimension statistics live in two memories with one write port and one
  // registered read port each. The read is issued on the accepting edge, so the
  // stored mean and M2 are ready in the first working state.
  logic [MeanW-1:0] avg_mem [DIM_MAX];
  logic [M2W-1:0]   m2_mem  [DIM_MAX];
  logic [MeanW-1:0] rd_avg_q;
  logic [M2W-1:0]   rd_m2_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MeanW-1:0] mem_wavg;
  logic [M2W-1:0]   mem_wm2;
  logic [AW-1:0]    rd_addr;

  wrn_state_e state_q, state_d;
  logic [31:0]    count_q;
  logic [31:0]    eps_q;
  logic [30:0]    clip_q;
  logic [AW-1:0]  clr_cnt_q;
  logic           out_valid_q;
  wrn_out_t       out_q;

  // Work registers of the item in flight.
  logic               op_q;
  logic               oor_q;
  logic [AW-1:0]      addr_q;
  logic signed [MeanW-1:0] x_q;
  logic signed [MeanW-1:0] mean_q;
  logic [M2W-1:0]     m2_q;
  logic [DevW-1:0]    mag_q;
  logic               neg_q;
  logic [DevW-1:0]    mb_q;
  logic [ProdW-1:0]   prod_q;
  logic [$clog2(MulSteps)-1:0] mul_cnt_q;
  logic [M2W-1:0]     var_q;
  logic [M2W-1:0]     sq_v_q;
  logic [M2W-1:0]     sq_r_q;
  logic [M2W-1:0]     sq_bit_q;
  logic signed [31:0] norm_q;

  wrn_div_req_t div_req;
  wrn_div_rsp_t div_rsp;

  logic            in_accept;
  logic            in_range;
  logic            out_free;
  logic signed [DevW-1:0] diff_rd;
  logic [DevW-1:0] mag_rd;
  logic [31:0]     n_div;
  logic [MeanW-1:0] mean_new;
  logic signed [DevW-1:0] dev;
  logic [DevW:0]   mul_sum;
  logic [M2W-1:0]  inc;
  logic [M2W:0]    m2_sum;
  logic [M2W:0]    v_sum;
  logic [M2W-1:0]  sq_t;
  logic            sq_fit;
  logic signed [32:0] r_sat;
  logic signed [32:0] r_clip;
  logic signed [32:0] clip_ext;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = 32'(in_data_i.elem_index) < DIM_MAX;
  assign rd_addr     = AW'(in_data_i.elem_index);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Difference of the sample and the stored mean as read from memory.
  assign diff_rd = DevW'(x_q) - DevW'($signed(rd_avg_q));
  assign mag_rd  = diff_rd[DevW-1] ? DevW'(-diff_rd) : DevW'(diff_rd);
  assign n_div   = (count_q == '0) ? 32'd1 : count_q;

  assign mean_new = neg_q ? MeanW'(mean_q) - div_rsp.quotient[MeanW-1:0]
                          : MeanW'(mean_q) + div_rsp.quotient[MeanW-1:0];
  assign dev      = DevW'(x_q) - DevW'(mean_q);

  // Right-shifting shift-add multiplier: one multiplier bit per cycle.
  assign mul_sum = {1'b0, prod_q[ProdW-1:DevW]} + (mb_q[0] ? {1'b0, mag_q} : '0);

  // The product is shifted down by 32 and saturates to 64 bits.
  assign inc    = (prod_q[ProdW-1:M2W+32] != '0) ? '1 : prod_q[M2W+31:32];
  assign m2_sum = {1'b0, m2_q} + {1'b0, inc};

  assign v_sum = {1'b0, div_rsp.quotient} + (M2W+1)'(eps_q);

  // One digit of the bitwise integer square root.
  assign sq_t   = sq_r_q + sq_bit_q;
  assign sq_fit = sq_v_q >= sq_t;

  // Saturate the quotient to a signed 32-bit value, then apply the clip bound.
  assign clip_ext = {2'b00, clip_q};
  always_comb begin
    if (mag_q == '0) begin
      r_sat = '0;
    end else if (!neg_q) begin
      r_sat = (div_rsp.quotient > 64'h7FFF_FFFF) ? 33'sh0_7FFF_FFFF
                                                : $signed({1'b0, div_rsp.quotient[31:0]});
    end else begin
      r_sat = (div_rsp.quotient > 64'h8000_0000) ? -33'sh0_8000_0000
                                                : -$signed({1'b0, div_rsp.quotient[31:0]});
    end
    r_clip = r_sat;
    if (clip_q != '0) begin
      if (r_sat > clip_ext) begin
        r_clip = clip_ext;
      end else if (r_sat < -clip_ext) begin
        r_clip = -clip_ext;
      end
    end
  end

  // Next state, divider launches and memory writes.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    mem_we           = 1'b0;
    mem_waddr        = addr_q;
    mem_wavg         = MeanW'(mean_q);
    mem_wm2          = m2_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wavg  = '0;
        mem_wm2   = '0;
        if (clr_cnt_q == AW'(DIM_MAX - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = in_range ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        if (op_q == OpUpdate) begin
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(mag_rd);
          div_req.divisor  = n_div;
          state_d          = ST_DIV_MEAN;
        end else if (count_q > 32'd1) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_m2_q;
          div_req.divisor  = count_q - 32'd1;
          state_d          = ST_DIV_VAR;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt_q == ($clog2(MulSteps))'(MulSteps - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (count_q > 32'd1) begin
          div_req.start    = 1'b1;
          div_req.dividend = m2_q;
          div_req.divisor  = count_q - 32'd1;
          state_d          = ST_DIV_VAR;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV_VAR: begin
        if (div_rsp.done) begin
          state_d = (op_q == OpUpdate) ? ST_OUT : ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_bit_q == '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(mag_q);
          div_req.divisor  = sq_r_q[DenW-1:0];
          state_d          = ST_DIV_NORM;
        end
      end
      ST_DIV_NORM: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      eps_q       <= '0;
      clip_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (in_accept && in_data_i.op == OpUpdate && in_data_i.elem_index == '0 &&
          count_q != '1) begin
        count_q <= count_q + 32'd1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgEps:  eps_q  <= cfg_data_i;
          CfgClip: clip_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      avg_mem[mem_waddr] <= mem_wavg;
      m2_mem[mem_waddr]  <= mem_wm2;
    end
    rd_avg_q <= avg_mem[rd_addr];
    rd_m2_q  <= m2_mem[rd_addr];
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_q   <= in_data_i.op;
          oor_q  <= !in_range;
          addr_q <= rd_addr;
          x_q    <= {in_data_i.sample, 16'h0000};
          norm_q <= '0;
          var_q  <= '0;
          mean_q <= '0;
        end
      end
      ST_READ: begin
        mean_q <= $signed(rd_avg_q);
        m2_q   <= rd_m2_q;
        mag_q  <= mag_rd;
        neg_q  <= diff_rd[DevW-1];
        // With fewer than two observations the variance used is one, plus the eps term.
        sq_v_q   <= (M2W)'(64'h1_0000_0000) + M2W'(eps_q);
        sq_r_q   <= '0;
        sq_bit_q <= M2W'(1) << (M2W - 2);
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          mean_q <= $signed(mean_new);
        end
      end
      ST_DEV: begin
        mb_q      <= dev[DevW-1] ? DevW'(-dev) : DevW'(dev);
        prod_q    <= '0;
        mul_cnt_q <= '0;
      end
      ST_MUL: begin
        prod_q    <= {mul_sum, prod_q[DevW-1:1]};
        mb_q      <= mb_q >> 1;
        mul_cnt_q <= mul_cnt_q + 1'b1;
      end
      ST_ACC: begin
        m2_q <= m2_sum[M2W] ? '1 : m2_sum[M2W-1:0];
      end
      ST_DIV_VAR: begin
        if (div_rsp.done) begin
          var_q    <= div_rsp.quotient;
          sq_v_q   <= v_sum[M2W] ? '1 : v_sum[M2W-1:0];
          sq_r_q   <= '0;
          sq_bit_q <= M2W'(1) << (M2W - 2);
        end
      end
      ST_SQRT: begin
        if (sq_bit_q != '0) begin
          if (sq_fit) begin
            sq_v_q <= sq_v_q - sq_t;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      ST_DIV_NORM: begin
        if (div_rsp.done) begin
          norm_q <= r_clip[31:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_q.obs_count_out <= count_q;
          if (oor_q) begin
            out_q.avg_out        <= '0;
            out_q.variance_out   <= '0;
            out_q.normalized_out <= '0;
          end else begin
            out_q.avg_out        <= mean_q[MeanW-1:16];
            out_q.variance_out   <= (var_q[M2W-1:48] != '0) ? '1 : var_q[47:16];
            out_q.normalized_out <= norm_q;
          end
        end
      end
      default: ;
    endcase
  end

  wrn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

[rtl/wrn_div.sv]
module wrn_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wrn_pkg::wrn_div_req_t req_i,
  output wrn_pkg::wrn_div_rsp_t rsp_o
);
  import wrn_pkg::*;

  // Restoring divider, one quotient bit per cycle. A zero divisor yields all ones.
  logic [DivW-1:0]             quo_q;
  logic [DenW-1:0]             rem_q;
  logic [DenW-1:0]             den_q;
  logic [$clog2(DivW)-1:0]     cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [DenW:0]               trial;
  logic                        fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
